>>> rtl/ppu_register_port_defines.svh
// ---------------------------------------------------------------------------
// ppu_register_port_defines
// Assertion macros shared by the picture-unit register port checks
// ---------------------------------------------------------------------------
`ifndef PPU_REGISTER_PORT_DEFINES_SVH
`define PPU_REGISTER_PORT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define PPU_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ppu register port check failed");

// next-cycle implication, sampled on clk, off during reset
`define PPU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ppu register port check failed");

`endif

>>> rtl/ppu_pkg.sv
// ---------------------------------------------------------------------------
// ppu_pkg
// Codes, sizes and flag positions of the picture-unit register port
// ---------------------------------------------------------------------------
package ppu_pkg;

  // access modes
  localparam logic [1:0] MODE_READ   = 2'd0;
  localparam logic [1:0] MODE_WRITE  = 2'd1;
  localparam logic [1:0] MODE_STATUS = 2'd2;

  // register numbers (low three address bits)
  localparam logic [2:0] REG_CONTROL = 3'd0;
  localparam logic [2:0] REG_MASK    = 3'd1;
  localparam logic [2:0] REG_STATUS  = 3'd2;
  localparam logic [2:0] REG_SPR_ADR = 3'd3;
  localparam logic [2:0] REG_SPR_DAT = 3'd4;
  localparam logic [2:0] REG_SCROLL  = 3'd5;
  localparam logic [2:0] REG_VID_ADR = 3'd6;
  localparam logic [2:0] REG_VID_DAT = 3'd7;

  // store sizes
  localparam int SPRITE_DEPTH  = 256;
  localparam int PALETTE_DEPTH = 32;
  localparam int VIDEO_DEPTH   = 16384;
  localparam int SPR_AW = $clog2(SPRITE_DEPTH);
  localparam int PAL_AW = $clog2(PALETTE_DEPTH);

  // flags and address decode
  localparam logic [7:0]  FLAG_BLANK   = 8'h80;
  localparam int          INC32_BIT    = 2;
  localparam int          VADR_BITS    = 14;
  localparam logic [13:0] PALETTE_BASE = 14'h3F00;
  localparam logic [15:0] STEP_ONE     = 16'd1;
  localparam logic [15:0] STEP_ROW     = 16'd32;

endpackage

>>> rtl/ppu_if.sv
// ---------------------------------------------------------------------------
// ppu_if
// Request and response channels of the picture-unit register port
// ---------------------------------------------------------------------------
interface ppu_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [2:0] register_select;
  logic [7:0] write_data;

  modport source (output valid, output mode, output register_select,
                  output write_data, input ready);
  modport sink   (input valid, input mode, input register_select,
                  input write_data, output ready);
endinterface

interface ppu_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       access_error;

  modport source (output valid, output read_data, output access_error, input ready);
  modport sink   (input valid, input read_data, input access_error, output ready);
endinterface

>>> rtl/ppu_ram.sv
// ---------------------------------------------------------------------------
// ppu_ram
// Generic single-write, single-read RAM with registered read data
// ---------------------------------------------------------------------------
module ppu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port, holds when not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/ppu_register_port.sv
// ---------------------------------------------------------------------------
// ppu_register_port
// CPU-side register port of a picture unit: eight mirrored registers,
// sprite-memory port, scroll and video address pairs, video data port
// ---------------------------------------------------------------------------
// channel   | dir | payload                                | handshake
// request   | in  | mode, register_select, write_data      | valid/ready
// response  | out | read_data, access_error                | valid/ready
//
// One item per cycle while results are taken; the result appears the cycle after acceptance.
// Sprite-port reads take their byte from the sprite RAM's registered
// read port, which holds while the result waits.
// A new item is taken whenever the response register is empty or drains.
// Synchronous reset clears registers and the sprite valid bits at once;
// no clearing pass. The video store has no defined reset contents.
module ppu_register_port
  import ppu_pkg::*;
#(
  parameter int VideoDepth = VIDEO_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  ppu_req_if.sink   request,
  ppu_rsp_if.source response
);

  localparam int VID_AW = $clog2(VideoDepth);
  localparam logic [VADR_BITS-1:0] VidDepthW = VADR_BITS'(VideoDepth);

  // architectural registers
  logic [7:0]        control;
  logic [7:0]        mask;
  logic [7:0]        status;
  logic [SPR_AW-1:0] spr_addr;
  logic [7:0]        scroll [2];
  logic              toggle;
  logic [15:0]       vid_addr;
  logic [SPRITE_DEPTH-1:0] spr_valid;

  // response register
  logic       rsp_valid;
  logic       rsp_err;
  logic [7:0] rsp_byte;
  logic       rsp_from_spr;
  logic       rsp_spr_hit;
  logic [7:0] spr_rdata;

  // decode
  logic              acc;
  logic              is_rd;
  logic              is_wr;
  logic              err_now;
  logic [7:0]        byte_now;
  logic              spr_rd;
  logic              spr_wr;
  logic              vid_advance;
  logic              data_wr;
  logic [VADR_BITS-1:0] vadr;
  logic              to_palette;
  logic [VADR_BITS-1:0] vid_idx_full;
  logic [15:0]       vid_step;

  assign acc   = request.valid && request.ready;
  assign is_rd = (request.mode == MODE_READ);
  assign is_wr = (request.mode == MODE_WRITE);

  // accept while the response slot is free or being taken
  assign request.ready = !rsp_valid || response.ready;

  // result and side-effect decode
  always_comb begin
    err_now     = 1'b0;
    byte_now    = 8'd0;
    spr_rd      = 1'b0;
    spr_wr      = 1'b0;
    vid_advance = 1'b0;
    data_wr     = 1'b0;
    case (request.mode)
      MODE_READ: begin
        case (request.register_select)
          REG_STATUS:  byte_now = status;
          REG_SPR_DAT: spr_rd = 1'b1;
          REG_VID_DAT: begin
            vid_advance = 1'b1;
            err_now     = 1'b1;
          end
          default:     err_now = 1'b1;
        endcase
      end
      MODE_WRITE: begin
        case (request.register_select)
          REG_STATUS:  err_now = 1'b1;
          REG_SPR_DAT: spr_wr = 1'b1;
          REG_VID_DAT: begin
            data_wr     = 1'b1;
            vid_advance = 1'b1;
          end
          default:     err_now = 1'b0;
        endcase
      end
      MODE_STATUS: err_now = 1'b0;
      default:     err_now = 1'b1;
    endcase
  end

  // video data port address decode
  assign vadr       = vid_addr[VADR_BITS-1:0];
  assign to_palette = (vadr >= PALETTE_BASE);
  assign vid_step   = control[INC32_BIT] ? STEP_ROW : STEP_ONE;

  // 14-bit address folded into the video store, at most three subtractions
  always_comb begin
    vid_idx_full = vadr;
    for (int i = 0; i < 3; i++) begin
      if (vid_idx_full >= VidDepthW) begin
        vid_idx_full = vid_idx_full - VidDepthW;
      end
    end
  end

  // register state and response valid
  always_ff @(posedge clk) begin
    if (rst) begin
      control   <= '0;
      mask      <= '0;
      status    <= '0;
      spr_addr  <= '0;
      scroll[0] <= '0;
      scroll[1] <= '0;
      toggle    <= 1'b0;
      vid_addr  <= '0;
      spr_valid <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (acc) begin
        rsp_valid <= 1'b1;
        if (spr_rd || spr_wr) begin
          spr_addr <= spr_addr + SPR_AW'(1);
        end
        if (spr_wr) begin
          spr_valid[spr_addr] <= 1'b1;
        end
        if (vid_advance) begin
          vid_addr <= vid_addr + vid_step;
        end
        if (request.mode == MODE_STATUS) begin
          status <= request.write_data;
        end else if (is_rd && request.register_select == REG_STATUS) begin
          status <= status & FLAG_BLANK;
        end
        if (is_wr) begin
          case (request.register_select)
            REG_CONTROL: control  <= request.write_data;
            REG_MASK:    mask     <= request.write_data;
            REG_SPR_ADR: spr_addr <= request.write_data;
            REG_SCROLL: begin
              scroll[toggle] <= request.write_data;
              toggle         <= ~toggle;
            end
            REG_VID_ADR: begin
              if (toggle) begin
                vid_addr[7:0]  <= request.write_data;
              end else begin
                vid_addr[15:8] <= request.write_data;
              end
              toggle <= ~toggle;
            end
            default: toggle <= toggle;
          endcase
        end
      end else if (response.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // response payload
  always_ff @(posedge clk) begin
    if (acc) begin
      rsp_err      <= err_now;
      rsp_byte     <= byte_now;
      rsp_from_spr <= spr_rd;
      rsp_spr_hit  <= spr_valid[spr_addr];
    end
  end

  // sprite memory, read at acceptance, written at acceptance
  ppu_ram #(
    .WIDTH (8),
    .DEPTH (SPRITE_DEPTH)
  ) u_spr_ram (
    .clk     (clk),
    .wr_en   (acc && spr_wr),
    .wr_addr (spr_addr),
    .wr_data (request.write_data),
    .rd_en   (acc && spr_rd),
    .rd_addr (spr_addr),
    .rd_data (spr_rdata)
  );

  // palette memory, only written through this port
  ppu_ram #(
    .WIDTH (8),
    .DEPTH (PALETTE_DEPTH)
  ) u_pal_ram (
    .clk     (clk),
    .wr_en   (acc && data_wr && to_palette),
    .wr_addr (vadr[PAL_AW-1:0]),
    .wr_data (request.write_data),
    .rd_en   (1'b0),
    .rd_addr ('0),
    .rd_data ()
  );

  // video memory, only written through this port
  ppu_ram #(
    .WIDTH (8),
    .DEPTH (VideoDepth)
  ) u_vid_ram (
    .clk     (clk),
    .wr_en   (acc && data_wr && !to_palette),
    .wr_addr (vid_idx_full[VID_AW-1:0]),
    .wr_data (request.write_data),
    .rd_en   (1'b0),
    .rd_addr ('0),
    .rd_data ()
  );

  // response outputs; unwritten sprite entries read as zero
  assign response.valid        = rsp_valid;
  assign response.access_error = rsp_err;
  assign response.read_data    = rsp_from_spr ? (rsp_spr_hit ? spr_rdata : 8'd0)
                                              : rsp_byte;

endmodule

>>> rtl/ppu_checker.sv
// ---------------------------------------------------------------------------
// ppu_checker
// Port-level checks of the picture-unit register port, bound to the top
// ---------------------------------------------------------------------------
`include "ppu_register_port_defines.svh"

module ppu_checker
  import ppu_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic [1:0] req_mode,
  input logic [2:0] req_sel,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [7:0] rsp_data,
  input logic       rsp_error
);

  logic req_acc;
  logic wr_ok;
  logic rd_bad;

  assign req_acc = req_valid && req_ready;
  assign wr_ok   = req_acc && req_mode == MODE_WRITE && req_sel != REG_STATUS;
  assign rd_bad  = req_acc && req_mode == MODE_READ &&
                   req_sel != REG_STATUS && req_sel != REG_SPR_DAT;

  // a waiting result stays until taken
  `PPU_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
  // an accepted item gives its result in the next cycle
  `PPU_ASSERT_NEXT(a_rsp_follows, req_acc, rsp_valid)
  // writes to writable registers answer zero without error
  `PPU_ASSERT_NEXT(a_write_clean, wr_ok, rsp_data == 8'd0 && !rsp_error)
  // reads of write-only or unimplemented registers answer zero with error
  `PPU_ASSERT_NEXT(a_read_error, rd_bad, rsp_data == 8'd0 && rsp_error)

endmodule

bind ppu_register_port ppu_checker u_ppu_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (request.valid),
  .req_ready (request.ready),
  .req_mode  (request.mode),
  .req_sel   (request.register_select),
  .rsp_valid (response.valid),
  .rsp_ready (response.ready),
  .rsp_data  (response.read_data),
  .rsp_error (response.access_error)
);

>>> sim/tb.sv
// ---------------------------------------------------------------------------
// tb
// Checks the picture-unit register port against a cycle-free shadow of its
// registers and stores. Directed accesses hit the register extremes, then
// random access sequences run with random idle bursts on both channels.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ppu_pkg::*;

  localparam int RANDOM_ITEMS = 1050;
  localparam int STEADY_ITEMS = 150;
  localparam int LONG_HOLD    = 50;
  localparam int QUIET_LIMIT  = 500;
  localparam int DRAIN_CYCLES = 4;

  typedef struct packed {
    logic [7:0] read_data;
    logic       access_error;
  } reply_t;

  // shadow of the register port state, holds the replies still due
  class register_shadow;
    logic [7:0]  control;
    logic [7:0]  mask;
    logic [7:0]  status;
    logic [7:0]  spr_addr;
    logic [7:0]  sprite_mem [SPRITE_DEPTH];
    logic [7:0]  scroll [2];
    logic        toggle;
    logic [15:0] vaddr;
    logic [7:0]  palette [PALETTE_DEPTH];
    reply_t      due [$];
    int          mismatches;

    function new();
      control    = '0;
      mask       = '0;
      status     = '0;
      spr_addr   = '0;
      toggle     = 1'b0;
      vaddr      = '0;
      mismatches = 0;
      scroll[0]  = '0;
      scroll[1]  = '0;
      foreach (sprite_mem[i]) sprite_mem[i] = '0;
      foreach (palette[i]) palette[i] = '0;
    endfunction

    function int outstanding();
      return due.size();
    endfunction

    function void step_video();
      vaddr = vaddr + (control[INC32_BIT] ? STEP_ROW : STEP_ONE);
    endfunction

    task report_mismatch(string what, int got, int want);
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
      mismatches++;
    endtask

    // predict the reply of one accepted access and update the shadow
    function void note_access(logic [1:0] mode, logic [2:0] sel, logic [7:0] data);
      reply_t r;
      logic [13:0] a;
      r = '0;
      if (mode == MODE_READ) begin
        case (sel)
          REG_STATUS: begin
            r.read_data = status;
            status = status & FLAG_BLANK;
          end
          REG_SPR_DAT: begin
            r.read_data = sprite_mem[spr_addr];
            spr_addr = spr_addr + 8'd1;
          end
          REG_VID_DAT: begin
            step_video();
            r.access_error = 1'b1;
          end
          default: r.access_error = 1'b1;
        endcase
      end else if (mode == MODE_WRITE) begin
        case (sel)
          REG_CONTROL: control = data;
          REG_MASK:    mask = data;
          REG_STATUS:  r.access_error = 1'b1;
          REG_SPR_ADR: spr_addr = data;
          REG_SPR_DAT: begin
            sprite_mem[spr_addr] = data;
            spr_addr = spr_addr + 8'd1;
          end
          REG_SCROLL: begin
            scroll[toggle] = data;
            toggle = ~toggle;
          end
          REG_VID_ADR: begin
            if (toggle) vaddr[7:0] = data;
            else vaddr[15:8] = data;
            toggle = ~toggle;
          end
          default: begin
            // video store contents never reach an output, only the palette is kept
            a = vaddr[VADR_BITS-1:0];
            if (a >= PALETTE_BASE) palette[a[PAL_AW-1:0]] = data;
            step_video();
          end
        endcase
      end else if (mode == MODE_STATUS) begin
        status = data;
      end else begin
        r.access_error = 1'b1;
      end
      due.push_back(r);
    endfunction

    // compare one accepted reply with the oldest one due
    task check_reply(logic [7:0] read_data, logic access_error);
      reply_t want;
      if (due.size() == 0) begin
        report_mismatch("reply with none due, read_data", read_data, 0);
      end else begin
        want = due.pop_front();
        if (read_data !== want.read_data)
          report_mismatch("read_data", read_data, want.read_data);
        if (access_error !== want.access_error)
          report_mismatch("access_error", access_error, want.access_error);
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  ppu_req_if req_ch ();
  ppu_rsp_if rsp_ch ();

  register_shadow shadow = new();

  int items_sent = 0;
  bit steady = 1'b0;
  bit long_hold_req = 1'b0;
  int stall_left = 0;
  bit long_active = 1'b0;
  int quiet_cycles = 0;

  ppu_register_port DUT (
    .clk      (clk),
    .rst      (rst),
    .request  (req_ch),
    .response (rsp_ch)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // response side: random stalls, one long hold-off on request
  initial begin : reply_sink
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        long_active = 1'b1;
        stall_left = LONG_HOLD - 1;
        rsp_ch.ready <= 1'b0;
      end else if (!steady && $urandom_range(0, 7) == 0) begin
        long_active = 1'b0;
        stall_left = $urandom_range(0, 9);
        rsp_ch.ready <= 1'b0;
      end else begin
        long_active = 1'b0;
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // check every accepted reply
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      shadow.check_reply(rsp_ch.read_data, rsp_ch.access_error);
  end

  // watchdog on cycles with no item moving
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // random idle burst on the request side, none during the sink's long hold-off
  task automatic maybe_idle();
    if (!steady && !long_hold_req && !long_active && $urandom_range(0, 5) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
  endtask

  // offer one access at the falling edge and hold it until taken
  task automatic send_access(input logic [1:0] mode, input logic [2:0] sel,
                             input logic [7:0] data);
    req_ch.valid           <= 1'b1;
    req_ch.mode            <= mode;
    req_ch.register_select <= sel;
    req_ch.write_data      <= data;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    shadow.note_access(mode, sel, data);
    items_sent++;
    @(negedge clk);
    maybe_idle();
  endtask

  // sprite burst: write a run, then read it back from the same start
  task automatic sprite_burst();
    logic [7:0] start;
    int n;
    start = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(248, 255)) : 8'($urandom);
    n = $urandom_range(1, 8);
    send_access(MODE_WRITE, REG_SPR_ADR, start);
    repeat (n) send_access(MODE_WRITE, REG_SPR_DAT, 8'($urandom));
    send_access(MODE_WRITE, REG_SPR_ADR, start);
    repeat (n) send_access(MODE_READ, REG_SPR_DAT, 8'($urandom));
  endtask

  // video burst: optional control, address pair, then data-port traffic
  task automatic video_burst();
    logic [7:0] high;
    int n;
    case ($urandom_range(0, 3))
      0: high = 8'h3F;
      1: high = 8'h3E;
      2: high = 8'h3F | (8'($urandom) & 8'hC0);
      default: high = 8'($urandom);
    endcase
    if ($urandom_range(0, 2) == 0) send_access(MODE_WRITE, REG_CONTROL, 8'($urandom));
    send_access(MODE_WRITE, REG_VID_ADR, high);
    send_access(MODE_WRITE, REG_VID_ADR, ($urandom_range(0, 1) == 0) ? 8'($urandom_range(224, 255))
                                                                   : 8'($urandom));
    n = $urandom_range(1, 10);
    repeat (n) begin
      if ($urandom_range(0, 3) == 0) send_access(MODE_READ, REG_VID_DAT, 8'($urandom));
      else send_access(MODE_WRITE, REG_VID_DAT, 8'($urandom));
    end
  endtask

  // status update followed by reads
  task automatic status_burst();
    send_access(MODE_STATUS, 3'($urandom), 8'($urandom));
    repeat ($urandom_range(1, 3)) send_access(MODE_READ, REG_STATUS, 8'($urandom));
  endtask

  // stimulus
  initial begin : stimulus
    bit long_done;
    long_done = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.mode = MODE_READ;
    req_ch.register_select = REG_CONTROL;
    req_ch.write_data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: status behavior, error paths, sprite wrap, address extremes
    send_access(MODE_READ,   REG_STATUS,  8'h00);
    send_access(MODE_STATUS, REG_CONTROL, 8'hFF);
    send_access(MODE_READ,   REG_STATUS,  8'h00);
    send_access(MODE_READ,   REG_STATUS,  8'hFF);
    send_access(MODE_WRITE,  REG_STATUS,  8'hFF);
    send_access(MODE_READ,   REG_CONTROL, 8'h00);
    send_access(MODE_READ,   REG_MASK,    8'h00);
    send_access(MODE_READ,   REG_SPR_ADR, 8'h00);
    send_access(MODE_READ,   REG_SCROLL,  8'h00);
    send_access(MODE_READ,   REG_VID_ADR, 8'h00);
    send_access(MODE_WRITE,  REG_CONTROL, 8'hFF);
    send_access(MODE_WRITE,  REG_MASK,    8'hFF);
    send_access(MODE_WRITE,  REG_SPR_ADR, 8'hFF);
    send_access(MODE_WRITE,  REG_SPR_DAT, 8'hA5);
    send_access(MODE_WRITE,  REG_SPR_ADR, 8'hFF);
    send_access(MODE_READ,   REG_SPR_DAT, 8'h00);
    send_access(MODE_READ,   REG_SPR_DAT, 8'h00);
    send_access(MODE_WRITE,  REG_SCROLL,  8'h00);
    send_access(MODE_WRITE,  REG_SCROLL,  8'hFF);
    send_access(MODE_WRITE,  REG_VID_ADR, 8'hFF);
    send_access(MODE_WRITE,  REG_VID_ADR, 8'hFF);
    send_access(MODE_WRITE,  REG_VID_DAT, 8'h3C);
    send_access(MODE_READ,   REG_VID_DAT, 8'h00);
    send_access(MODE_WRITE,  REG_CONTROL, 8'h00);
    send_access(MODE_STATUS, REG_VID_DAT, 8'h00);

    // random access sequences
    while (items_sent < RANDOM_ITEMS) begin
      if (!long_done && items_sent > 400) begin
        long_done = 1'b1;
        long_hold_req = 1'b1;
      end
      steady = (items_sent >= RANDOM_ITEMS - STEADY_ITEMS);
      case ($urandom_range(0, 9))
        0, 1, 2: sprite_burst();
        3, 4, 5: video_burst();
        6: status_burst();
        7: begin
          send_access(MODE_WRITE, REG_SCROLL, 8'($urandom));
          send_access(MODE_WRITE, REG_SCROLL, 8'($urandom));
        end
        default: begin
          repeat ($urandom_range(1, 6))
            send_access(2'($urandom_range(MODE_READ, MODE_STATUS)), 3'($urandom), 8'($urandom));
        end
      endcase
    end
    req_ch.valid <= 1'b0;

    // drain
    while (shadow.outstanding() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (shadow.mismatches == 0 && shadow.outstanding() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
